### design/buffered_serial_byte_transmitter_top_assert.svh
// Assertion helpers used by the transmitter core RTL.
`ifndef BUFFERED_SERIAL_BYTE_TRANSMITTER_TOP_ASSERT_SVH
`define BUFFERED_SERIAL_BYTE_TRANSMITTER_TOP_ASSERT_SVH

// Invariant checked at every edge outside reset.
`define BSBT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define BSBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BSBT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bsbt_pkg.sv
package bsbt_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int IDX_W      = $clog2(FIFO_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int DATA_BITS  = 8;
  localparam int BITS_W     = 4;
  localparam int FREE_W     = 6;
  localparam int SUM_W      = (IDX_W > FREE_W) ? IDX_W : FREE_W;
  localparam int OUT_W      = 16;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [FREE_W-1:0] free_slots;
    logic              busy_res;
    logic              line_level;
    logic              accepted;
  } result_t;

endpackage

### design/bsbt_ram.sv
module bsbt_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/bsbt_core.sv
`include "buffered_serial_byte_transmitter_top_assert.svh"

module bsbt_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  bsbt_pkg::op_t                 op,
  input  logic [bsbt_pkg::BYTE_W-1:0]   data_byte,
  output bsbt_pkg::result_t             res
);

  localparam logic [bsbt_pkg::IDX_W-1:0] LAST_IDX = bsbt_pkg::IDX_W'(bsbt_pkg::FIFO_DEPTH - 1);

  bsbt_pkg::phase_t              phase, phase_next;
  logic [bsbt_pkg::IDX_W-1:0]    widx, ridx, ridx_next, w_wrap, r_wrap;
  logic [bsbt_pkg::IDX_W-1:0]    level, level_next;
  logic [bsbt_pkg::BYTE_W-1:0]   shift_byte, shift_byte_next;
  logic [bsbt_pkg::BITS_W-1:0]   bits_sent, bits_sent_next, bits_inc;
  logic                          line_out, line_out_next;
  logic                          full, do_send, do_tick, take_idle, take_stop, take;
  logic [bsbt_pkg::BYTE_W-1:0]   ram_q, head_byte, fwd_data;
  logic                          fwd_hit;
  logic [bsbt_pkg::SUM_W-1:0]    free_wide;

  assign w_wrap    = (widx == LAST_IDX) ? '0 : widx + bsbt_pkg::IDX_W'(1);
  assign r_wrap    = (ridx == LAST_IDX) ? '0 : ridx + bsbt_pkg::IDX_W'(1);
  assign full      = (w_wrap == ridx);
  assign do_send   = acc && (op == bsbt_pkg::OP_SEND) && !full;
  assign do_tick   = acc && (op == bsbt_pkg::OP_TICK);
  assign take_idle = do_send && (phase == bsbt_pkg::PH_IDLE);
  assign take_stop = do_tick && (phase == bsbt_pkg::PH_STOP) && (level != '0);
  assign take      = take_idle || take_stop;
  assign ridx_next = take ? r_wrap : ridx;
  assign bits_inc  = bits_sent + bsbt_pkg::BITS_W'(1);

  // head entry, bypassed when it was written in the cycle it was read
  assign head_byte = take_idle ? data_byte : (fwd_hit ? fwd_data : ram_q);

  bsbt_ram #(
    .DATA_W (bsbt_pkg::BYTE_W),
    .DEPTH  (bsbt_pkg::FIFO_DEPTH),
    .ADDR_W (bsbt_pkg::IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_send),
    .wr_addr (widx),
    .wr_data (data_byte),
    .rd_addr (ridx_next),
    .rd_data (ram_q)
  );

  always_comb begin
    phase_next = phase;
    case (phase)
      bsbt_pkg::PH_IDLE: begin
        if (take_idle) phase_next = bsbt_pkg::PH_START;
      end
      bsbt_pkg::PH_START: begin
        if (do_tick) phase_next = bsbt_pkg::PH_DATA;
      end
      bsbt_pkg::PH_DATA: begin
        if (do_tick && bits_inc >= bsbt_pkg::BITS_W'(bsbt_pkg::DATA_BITS)) begin
          phase_next = bsbt_pkg::PH_STOP;
        end
      end
      bsbt_pkg::PH_STOP: begin
        if (do_tick) phase_next = (level != '0) ? bsbt_pkg::PH_START : bsbt_pkg::PH_IDLE;
      end
      default: phase_next = bsbt_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    line_out_next   = line_out;
    shift_byte_next = shift_byte;
    bits_sent_next  = bits_sent;
    if (do_tick) begin
      case (phase)
        bsbt_pkg::PH_START: begin
          line_out_next  = 1'b0;
          bits_sent_next = '0;
        end
        bsbt_pkg::PH_DATA: begin
          line_out_next   = shift_byte[0];
          shift_byte_next = shift_byte >> 1;
          bits_sent_next  = bits_inc;
        end
        bsbt_pkg::PH_STOP: begin
          line_out_next = 1'b1;
        end
        default: ;
      endcase
    end
    if (take) begin
      shift_byte_next = head_byte;
      bits_sent_next  = '0;
    end
    case ({do_send, take})
      2'b10:   level_next = level + bsbt_pkg::IDX_W'(1);
      2'b01:   level_next = level - bsbt_pkg::IDX_W'(1);
      default: level_next = level;
    endcase
  end

  assign free_wide = bsbt_pkg::SUM_W'(bsbt_pkg::FIFO_DEPTH - 1) - bsbt_pkg::SUM_W'(level_next);

  assign res.accepted   = do_send;
  assign res.line_level = line_out_next;
  assign res.busy_res   = (phase_next != bsbt_pkg::PH_IDLE);
  assign res.free_slots = free_wide[bsbt_pkg::FREE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= bsbt_pkg::PH_IDLE;
      widx       <= '0;
      ridx       <= '0;
      level      <= '0;
      shift_byte <= '0;
      bits_sent  <= '0;
      line_out   <= 1'b1;
      fwd_hit    <= 1'b0;
    end else begin
      phase      <= phase_next;
      if (do_send) widx <= w_wrap;
      ridx       <= ridx_next;
      level      <= level_next;
      shift_byte <= shift_byte_next;
      bits_sent  <= bits_sent_next;
      line_out   <= line_out_next;
      fwd_hit    <= do_send && (widx == ridx_next);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= data_byte;
  end

  `BSBT_ASSERT_IMP(a_idle_empty, phase == bsbt_pkg::PH_IDLE, level == '0 && line_out, "idle with queued bytes or low line")
  `BSBT_ASSERT(a_level_max, level <= LAST_IDX, "queue level above capacity")
  `BSBT_ASSERT_NXT(a_take_idle, take_idle, phase == bsbt_pkg::PH_START && shift_byte == $past(data_byte) && level == '0, "byte sent to idle line not loaded")
  `BSBT_ASSERT_NXT(a_full_hold, acc && op == bsbt_pkg::OP_SEND && full, level == $past(level) && widx == $past(widx), "refused byte changed the queue")

endmodule

### design/buffered_serial_byte_transmitter_top.sv
// channel  dir  tdata                                       tuser
// s_*      in   [7:0] data_byte                             [0] operation
// m_*      out  [0] accepted [1] line_level [2] busy_res    none
//               [8:3] free_slots [15:9] zero
// One item per cycle while s_tready is high; its result is registered and shows in the cycle after the transfer.
// Queue and framing state update in that same cycle; the head byte comes from a
// RAM with a registered read, with a bypass when it is written as it is read.
// rst is synchronous; no clearing pass, the block takes items the cycle after reset.
// s_tready drops only while a result waits and m_tready is low.
module buffered_serial_byte_transmitter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] data_byte
  input  logic                        s_tuser,  // [0] operation
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bsbt_pkg::OUT_W-1:0]  m_tdata   // accepted, line_level, busy_res, free_slots
);

  logic              acc;
  bsbt_pkg::result_t res;

  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  bsbt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .op        (bsbt_pkg::op_t'(s_tuser)),
    .data_byte (s_tdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_tdata <= bsbt_pkg::OUT_W'(res);
    end
  end

endmodule
